// File: rtl/crct_pkg.sv
// shared types and constants for the convex region containment test core
// no dependencies
`default_nettype none

package crct_pkg;

  // number of plane slots
  localparam int unsigned MaxPlanes = 6;

  // width of a plane index or count
  localparam int unsigned CountW = 3;

  // apb data and address widths
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned ApbAddrW = 6;

  // exact distance width, wide enough for n.p + 256*d and +/- the box extent
  localparam int unsigned DistW = 36;

  // input and output payload widths
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 8;

  // register indexes
  typedef enum logic [CountW-1:0] {
    REG_PLANE_COUNT = 3'd0,
    REG_PLANE_ZERO  = 3'd1,
    REG_PLANE_ONE   = 3'd2,
    REG_PLANE_TWO   = 3'd3,
    REG_PLANE_THREE = 3'd4,
    REG_PLANE_FOUR  = 3'd5,
    REG_PLANE_FIVE  = 3'd6
  } reg_idx_e;

  // test kinds
  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_OUTSIDE   = 2'd1,
    VERDICT_INTERSECT = 2'd2
  } verdict_e;

  // all plane words
  typedef logic [MaxPlanes-1:0][63:0] plane_arr_t;

  // per-plane result flags
  typedef struct packed {
    logic center_neg;   // center distance below zero
    logic below_rad;    // center distance below minus the radius
    logic all_out;      // farthest corner still below zero
    logic any_out;      // nearest corner below zero
  } lane_flags_t;

  typedef lane_flags_t [MaxPlanes-1:0] lane_flags_arr_t;

endpackage

`default_nettype wire

// File: rtl/crct_cfg.sv
// apb register file holding the plane count and the six plane words
// depends on crct_pkg
`default_nettype none

module crct_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crct_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [crct_pkg::ApbDataW-1:0] pwdata,
  output logic      [crct_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  output logic      [crct_pkg::CountW-1:0]   plane_count_o,
  output crct_pkg::plane_arr_t               planes_o
);

  logic [crct_pkg::CountW-1:0] plane_count_q;
  crct_pkg::plane_arr_t        planes_q;
  crct_pkg::reg_idx_e          idx;
  logic                        wr_en;

  assign idx    = crct_pkg::reg_idx_e'(paddr[crct_pkg::ApbAddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= crct_pkg::CountW'(crct_pkg::MaxPlanes);
      planes_q      <= '0;
    end else if (wr_en) begin
      case (idx)
        crct_pkg::REG_PLANE_COUNT: plane_count_q <= pwdata[crct_pkg::CountW-1:0];
        crct_pkg::REG_PLANE_ZERO:  planes_q[0] <= pwdata;
        crct_pkg::REG_PLANE_ONE:   planes_q[1] <= pwdata;
        crct_pkg::REG_PLANE_TWO:   planes_q[2] <= pwdata;
        crct_pkg::REG_PLANE_THREE: planes_q[3] <= pwdata;
        crct_pkg::REG_PLANE_FOUR:  planes_q[4] <= pwdata;
        crct_pkg::REG_PLANE_FIVE:  planes_q[5] <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      crct_pkg::REG_PLANE_COUNT: prdata = {{(crct_pkg::ApbDataW-crct_pkg::CountW){1'b0}},
                                           plane_count_q};
      crct_pkg::REG_PLANE_ZERO:  prdata = planes_q[0];
      crct_pkg::REG_PLANE_ONE:   prdata = planes_q[1];
      crct_pkg::REG_PLANE_TWO:   prdata = planes_q[2];
      crct_pkg::REG_PLANE_THREE: prdata = planes_q[3];
      crct_pkg::REG_PLANE_FOUR:  prdata = planes_q[4];
      crct_pkg::REG_PLANE_FIVE:  prdata = planes_q[5];
      default:                   prdata = '0;
    endcase
  end

  assign plane_count_o = plane_count_q;
  assign planes_o      = planes_q;

endmodule

`default_nettype wire

// File: rtl/crct_lane.sv
// one plane lane: products, exact distance and extent sums, sign compares
// three register stages sharing one advance enable; depends on crct_pkg
`default_nettype none

module crct_lane (
  input  wire logic                clk_i,
  input  wire logic                adv_i,
  input  wire logic [63:0]         plane_i,
  input  wire logic signed [15:0]  center_x_i,
  input  wire logic signed [15:0]  center_y_i,
  input  wire logic signed [15:0]  center_z_i,
  input  wire logic [14:0]         half_x_i,
  input  wire logic [14:0]         half_y_i,
  input  wire logic [14:0]         half_z_i,
  input  wire logic [14:0]         radius_s2_i,
  output crct_pkg::lane_flags_t    flags_o
);

  localparam int unsigned DW = crct_pkg::DistW;

  logic signed [15:0] nx, ny, nz, nd;
  logic [15:0]        ax, ay, az;

  // stage 1: products
  logic signed [31:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic [30:0]        ex_d, ey_d, ez_d, ex_q, ey_q, ez_q;
  logic signed [15:0] nd_q;
  // stage 2: sums
  logic signed [DW-1:0] dist_d, dist_q, ext_d, ext_q;
  // stage 3: flags
  logic signed [DW-1:0] rad_ext, near_v, far_v, rad_v;
  crct_pkg::lane_flags_t flags_d, flags_q;

  // unpack the plane word
  assign nx = $signed(plane_i[15:0]);
  assign ny = $signed(plane_i[31:16]);
  assign nz = $signed(plane_i[47:32]);
  assign nd = $signed(plane_i[63:48]);

  // magnitude of a signed value, most negative value included
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    if (v[15]) begin
      e = 17'(-e);
    end
    return e[15:0];
  endfunction

  assign ax = mag16(nx);
  assign ay = mag16(ny);
  assign az = mag16(nz);

  // center products and box extent products
  assign px_d = nx * center_x_i;
  assign py_d = ny * center_y_i;
  assign pz_d = nz * center_z_i;
  assign ex_d = ax * half_x_i;
  assign ey_d = ay * half_y_i;
  assign ez_d = az * half_z_i;

  // distance at the center and half spread over the box corners
  assign dist_d = DW'(px_q) + DW'(py_q) + DW'(pz_q) + (DW'(nd_q) <<< 8);
  assign ext_d  = $signed({{(DW-31){1'b0}}, ex_q}) + $signed({{(DW-31){1'b0}}, ey_q})
                + $signed({{(DW-31){1'b0}}, ez_q});

  // nearest corner, farthest corner, and sphere edge
  assign rad_ext = $signed({{(DW-23){1'b0}}, radius_s2_i, 8'b0});
  assign near_v  = dist_q - ext_q;
  assign far_v   = dist_q + ext_q;
  assign rad_v   = dist_q + rad_ext;

  always_comb begin
    flags_d.center_neg = dist_q[DW-1];
    flags_d.below_rad  = rad_v[DW-1];
    flags_d.all_out    = far_v[DW-1];
    flags_d.any_out    = near_v[DW-1];
  end

  // pipeline registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q    <= px_d;
      py_q    <= py_d;
      pz_q    <= pz_d;
      ex_q    <= ex_d;
      ey_q    <= ey_d;
      ez_q    <= ez_d;
      nd_q    <= nd;
      dist_q  <= dist_d;
      ext_q   <= ext_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

// File: rtl/convex_region_containment_test_core.sv
// top level of the convex region containment test core
// depends on crct_pkg, crct_cfg and crct_lane
`default_nettype none

// Tests a point, a sphere or an axis-aligned box against up to six planes.
// One request enters per cycle when the output is taken, and its result goes
// via products, distance sums, per-plane compares, then the verdict register
// that drives the output. Each plane has its own multiplier lane, so the
// throughput is one request per clock whenever the output is taken. A stall
// on the output freezes the whole pipeline. Program the plane registers
// only while no request is in flight.
module convex_region_containment_test_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crct_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [crct_pkg::ApbDataW-1:0] pwdata,
  output logic      [crct_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  // requests
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // operation, center_x, center_y, center_z, radius, half_x, half_y, half_z
  input  wire logic [crct_pkg::InDataW-1:0]  s_axis_tdata,
  // results
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // verdict, plane_inside_mask
  output logic      [crct_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned NP = crct_pkg::MaxPlanes;

  logic [crct_pkg::CountW-1:0] plane_count;
  crct_pkg::plane_arr_t        planes;

  logic [1:0]         in_op;
  logic signed [15:0] in_cx, in_cy, in_cz;
  logic [14:0]        in_r, in_hx, in_hy, in_hz;

  logic adv;
  logic v1_q, v2_q, v3_q, out_valid_q;
  crct_pkg::op_e op1_q, op2_q, op3_q;
  logic [14:0]   r1_q, r2_q;

  crct_pkg::lane_flags_arr_t flags;
  logic [NP-1:0]             use_mask;
  logic [crct_pkg::CountW-1:0] n_use;
  crct_pkg::verdict_e        verdict_d, verdict_q;
  logic [NP-1:0]             mask_d, mask_q;
  logic [NP-1:0]             neg_v, below_v, allout_v, mixed_v;

  // configuration registers
  crct_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .plane_count_o (plane_count),
    .planes_o      (planes)
  );

  // unpack request payload
  assign in_op = s_axis_tdata[1:0];
  assign in_cx = $signed(s_axis_tdata[17:2]);
  assign in_cy = $signed(s_axis_tdata[33:18]);
  assign in_cz = $signed(s_axis_tdata[49:34]);
  assign in_r  = s_axis_tdata[64:50];
  assign in_hx = s_axis_tdata[79:65];
  assign in_hy = s_axis_tdata[94:80];
  assign in_hz = s_axis_tdata[109:95];

  // the whole pipeline moves unless a result waits on the output
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= s_axis_tvalid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // side payload that travels with the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q     <= crct_pkg::op_e'(in_op);
      r1_q      <= in_r;
      op2_q     <= op1_q;
      r2_q      <= r1_q;
      op3_q     <= op2_q;
      verdict_q <= verdict_d;
      mask_q    <= mask_d;
    end
  end

  // one lane per plane
  for (genvar g = 0; g < NP; g++) begin : g_lane
    crct_lane u_lane (
      .clk_i,
      .adv_i       (adv),
      .plane_i     (planes[g]),
      .center_x_i  (in_cx),
      .center_y_i  (in_cy),
      .center_z_i  (in_cz),
      .half_x_i    (in_hx),
      .half_y_i    (in_hy),
      .half_z_i    (in_hz),
      .radius_s2_i (r2_q),
      .flags_o     (flags[g])
    );
  end

  // planes in use, count clamped to the slot number
  assign n_use = (plane_count > crct_pkg::CountW'(NP)) ? crct_pkg::CountW'(NP) : plane_count;

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      use_mask[i] = (crct_pkg::CountW'(i) < n_use);
      neg_v[i]    = use_mask[i] && flags[i].center_neg;
      below_v[i]  = use_mask[i] && flags[i].below_rad;
      allout_v[i] = use_mask[i] && flags[i].all_out;
      mixed_v[i]  = use_mask[i] && flags[i].any_out && !flags[i].all_out;
    end
  end

  // merge the plane flags into a verdict
  always_comb begin
    verdict_d = crct_pkg::VERDICT_INSIDE;
    mask_d    = '0;
    case (op3_q)
      crct_pkg::OP_POINT: begin
        if (|neg_v) verdict_d = crct_pkg::VERDICT_OUTSIDE;
      end
      crct_pkg::OP_SPHERE: begin
        if (|below_v) verdict_d = crct_pkg::VERDICT_OUTSIDE;
        mask_d = use_mask & ~below_v;
      end
      crct_pkg::OP_BOX: begin
        if (|allout_v) verdict_d = crct_pkg::VERDICT_OUTSIDE;
        else if (|mixed_v) verdict_d = crct_pkg::VERDICT_INTERSECT;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {mask_q, verdict_q};

  // checks

  // the intake is held exactly while a result waits
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !(out_valid_q && !m_axis_tready))
    else $error("intake ready does not follow the output stall");

  // a sphere mask never comes with an intersect verdict
  a_mask_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && mask_q != '0) |-> (verdict_q != crct_pkg::VERDICT_INTERSECT))
    else $error("plane mask set on a box verdict");

  // mask bits only for planes in use
  a_mask_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((mask_q & ~use_mask) == '0))
    else $error("plane mask bit set for a plane not in use");

  // a held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for convex_region_containment_test_core
// depends on crct_pkg and the core rtl; drives apb config and both streams
`timescale 1ns / 1ps

module tb_top;
  import crct_pkg::*;

  // the fields of one request carried on s_axis_tdata
  typedef struct packed {
    op_e                op;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [14:0]        radius;
    logic [14:0]        hx;
    logic [14:0]        hy;
    logic [14:0]        hz;
  } region_req_t;

  // the fields of one result carried on m_axis_tdata
  typedef struct packed {
    verdict_e    verdict;
    logic [5:0]  mask;
  } region_res_t;

  // what to change in the config before a directed row
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_COUNT,
    ACT_CUBE,
    ACT_STRAY
  } row_act_e;

  typedef struct packed {
    row_act_e    act;
    logic [2:0]  count;
    region_req_t rq;
    logic        has_want;
    region_res_t want;
  } dir_row_t;

  localparam logic [15:0] Z16 = 16'h0000;
  localparam logic [14:0] Z15 = 15'h0000;
  localparam region_res_t InsideClear = '{VERDICT_INSIDE, 6'h00};
  localparam region_res_t Unchecked   = '{VERDICT_INSIDE, 6'h00};

  // cube of half width 8.0 around the origin, planes packed {d, nz, ny, nx}
  localparam plane_arr_t CubePlanes = {
    64'h0800_FF00_0000_0000,  // z <= 8
    64'h0800_0100_0000_0000,  // z >= -8
    64'h0800_0000_FF00_0000,  // y <= 8
    64'h0800_0000_0100_0000,  // y >= -8
    64'h0800_0000_0000_FF00,  // x <= 8
    64'h0800_0000_0000_0100   // x >= -8
  };

  localparam int NDir = 25;
  localparam dir_row_t DirRows [NDir] = '{
    // reset config: every distance is zero
    '{ACT_NONE, 3'd0, '{OP_POINT, Z16, Z16, Z16, Z15, Z15, Z15, Z15}, 1'b1, InsideClear},
    '{ACT_NONE, 3'd0, '{OP_SPHERE, 16'h8000, 16'h8000, 16'h8000, 15'h7FFF, Z15, Z15, Z15},
      1'b1, '{VERDICT_INSIDE, 6'h3F}},
    '{ACT_NONE, 3'd0, '{OP_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF, Z15, 15'h7FFF, 15'h7FFF,
      15'h7FFF}, 1'b1, InsideClear},
    '{ACT_NONE, 3'd0, '{OP_NONE, 16'h1234, 16'hABCD, 16'h0F0F, 15'h7FFF, 15'h5555, 15'h2AAA,
      15'h7FFF}, 1'b1, InsideClear},
    '{ACT_NONE, 3'd0, '{OP_POINT, 16'h8000, 16'h7FFF, 16'h8000, Z15, Z15, Z15, Z15}, 1'b1,
      InsideClear},
    // cube region
    '{ACT_CUBE, 3'd0, '{OP_POINT, Z16, Z16, Z16, Z15, Z15, Z15, Z15}, 1'b0, Unchecked},
    '{ACT_NONE, 3'd0, '{OP_POINT, 16'h7FFF, Z16, Z16, Z15, Z15, Z15, Z15}, 1'b0, Unchecked},
    '{ACT_NONE, 3'd0, '{OP_POINT, 16'h8000, 16'h8000, 16'h8000, Z15, Z15, Z15, Z15}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_SPHERE, 16'h0C00, Z16, Z16, 15'h0500, Z15, Z15, Z15}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_SPHERE, 16'h0C00, Z16, Z16, 15'h0200, Z15, Z15, Z15}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_SPHERE, Z16, Z16, Z16, Z15, Z15, Z15, Z15}, 1'b0, Unchecked},
    '{ACT_NONE, 3'd0, '{OP_SPHERE, 16'h8000, 16'h7FFF, 16'h8000, 15'h7FFF, Z15, Z15, Z15},
      1'b0, Unchecked},
    '{ACT_NONE, 3'd0, '{OP_BOX, Z16, Z16, Z16, Z15, 15'h0100, 15'h0100, 15'h0100}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_BOX, Z16, Z16, Z16, Z15, 15'h7FFF, 15'h7FFF, 15'h7FFF}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_BOX, 16'h2800, Z16, Z16, Z15, 15'h0100, 15'h0100, 15'h0100}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_BOX, 16'h0800, Z16, Z16, Z15, 15'h0100, 15'h0100, 15'h0100}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_BOX, Z16, Z16, Z16, Z15, Z15, Z15, Z15}, 1'b0, Unchecked},
    '{ACT_NONE, 3'd0, '{OP_NONE, 16'h8000, 16'h7FFF, Z16, 15'h7FFF, 15'h7FFF, 15'h7FFF,
      15'h7FFF}, 1'b1, InsideClear},
    // no planes in use
    '{ACT_COUNT, 3'd0, '{OP_SPHERE, 16'h7FFF, 16'h7FFF, 16'h7FFF, Z15, Z15, Z15, Z15}, 1'b1,
      InsideClear},
    '{ACT_NONE, 3'd0, '{OP_BOX, 16'h8000, 16'h8000, 16'h8000, Z15, 15'h7FFF, 15'h7FFF,
      15'h7FFF}, 1'b1, InsideClear},
    // count above the plane slots acts as six
    '{ACT_COUNT, 3'd7, '{OP_SPHERE, 16'h0C00, Z16, Z16, 15'h0200, Z15, Z15, Z15}, 1'b0,
      Unchecked},
    '{ACT_NONE, 3'd0, '{OP_BOX, 16'h2800, Z16, Z16, Z15, 15'h0100, 15'h0100, 15'h0100}, 1'b0,
      Unchecked},
    '{ACT_COUNT, 3'd1, '{OP_POINT, 16'hEC00, Z16, Z16, Z15, Z15, Z15, Z15}, 1'b0, Unchecked},
    // write past the register list is dropped
    '{ACT_STRAY, 3'd0, '{OP_POINT, Z16, Z16, Z16, Z15, Z15, Z15, Z15}, 1'b0, Unchecked},
    '{ACT_COUNT, 3'd6, '{OP_SPHERE, 16'h0600, 16'hFA00, Z16, 15'h0300, Z15, Z15, Z15}, 1'b0,
      Unchecked}
  };

  localparam int NPhase     = 8;
  localparam int PhaseItems = 128;
  localparam logic [2:0] PhaseCounts [NPhase] = '{3'd6, 3'd7, 3'd0, 3'd6, 3'd3, 3'd5, 3'd1,
                                                  3'd4};

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // config shadow used by the predictor
  logic [2:0] cfg_count = 3'd6;
  plane_arr_t cfg_plane = '0;

  region_res_t predicted_results [$];
  int          errors = 0;
  bit          long_hold_due = 1'b0;

  convex_region_containment_test_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // exact signed distance n.p + 256*d of one plane
  function automatic longint plane_dist(logic [63:0] w, longint px, longint py, longint pz);
    return longint'($signed(w[15:0])) * px + longint'($signed(w[31:16])) * py +
           longint'($signed(w[47:32])) * pz + longint'($signed(w[63:48])) * 256;
  endfunction

  // verdict and inside mask for one request under the current config
  function automatic region_res_t classify(region_req_t rq);
    region_res_t res;
    longint      cx, cy, cz, rad, hx, hy, hz, px, py, pz, dv;
    int          n, i, c, outs;
    logic        all_out, mixed;
    cx = longint'($signed(rq.cx));
    cy = longint'($signed(rq.cy));
    cz = longint'($signed(rq.cz));
    rad = longint'(rq.radius);
    hx = longint'(rq.hx);
    hy = longint'(rq.hy);
    hz = longint'(rq.hz);
    n = (cfg_count > MaxPlanes) ? MaxPlanes : int'(cfg_count);
    res = '{VERDICT_INSIDE, 6'h00};
    all_out = 1'b0;
    mixed = 1'b0;
    case (rq.op)
      OP_POINT: begin
        for (i = 0; i < n; i++)
          if (plane_dist(cfg_plane[i], cx, cy, cz) < 0) res.verdict = VERDICT_OUTSIDE;
      end
      OP_SPHERE: begin
        for (i = 0; i < n; i++) begin
          dv = plane_dist(cfg_plane[i], cx, cy, cz);
          if (dv < -(rad * 256)) res.verdict = VERDICT_OUTSIDE;
          else res.mask[i] = 1'b1;
        end
      end
      OP_BOX: begin
        for (i = 0; i < n; i++) begin
          outs = 0;
          for (c = 0; c < 8; c++) begin
            px = c[0] ? cx + hx : cx - hx;
            py = c[2] ? cy + hy : cy - hy;
            pz = c[1] ? cz + hz : cz - hz;
            if (plane_dist(cfg_plane[i], px, py, pz) < 0) outs++;
          end
          if (outs == 8) all_out = 1'b1;
          else if (outs != 0) mixed = 1'b1;
        end
        if (all_out) res.verdict = VERDICT_OUTSIDE;
        else if (mixed) res.verdict = VERDICT_INTERSECT;
      end
      default: ;
    endcase
    return res;
  endfunction

  // one apb transfer: setup phase, then access until pready
  task automatic apb_access(input logic wr, input int idx, input logic [63:0] wdata,
                            output logic [63:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ApbAddrW'(idx * 8);
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input int idx, input logic [63:0] val);
    logic [63:0] unused;
    apb_access(1'b1, idx, val, unused);
    if (idx == REG_PLANE_COUNT) cfg_count = val[2:0];
    else if (idx <= REG_PLANE_FIVE) cfg_plane[idx - 1] = val;
  endtask

  task automatic reg_read_check(input int idx);
    logic [63:0] got, want;
    apb_access(1'b0, idx, 64'h0, got);
    want = (idx == REG_PLANE_COUNT) ? {61'h0, cfg_count} : cfg_plane[idx - 1];
    if (got !== want) begin
      $display("%0t: register %0d read mismatch: expected %h, got %h", $time, idx, want, got);
      errors++;
    end
  endtask

  // count and all six planes, then read every register back
  task automatic load_region(input logic [2:0] count, input plane_arr_t planes);
    int i;
    reg_write(REG_PLANE_COUNT, {61'h0, count});
    for (i = 0; i < MaxPlanes; i++) reg_write(REG_PLANE_ZERO + i, planes[i]);
    for (i = 0; i <= REG_PLANE_FIVE; i++) reg_read_check(i);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 85) return $urandom_range(1, 2);
    if (pick < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // offer one request, keeping tvalid high when there is no gap
  task automatic send_req(input region_req_t rq, input region_res_t want, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, rq.hz, rq.hy, rq.hx, rq.radius, rq.cz, rq.cy, rq.cx, rq.op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted_results.insert(predicted_results.size(), want);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4, 5, 6: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] rand_extent();
    case ($urandom_range(0, 9))
      0: return 15'h0000;
      1: return 15'h7FFF;
      2, 3, 4, 5, 6: return 15'($urandom_range(0, 2047));
      default: return 15'($urandom);
    endcase
  endfunction

  // result side: check accepted results, then drive tready for the next cycle
  initial begin : result_sink
    region_res_t got, want;
    int          stall_left, calm_left, pick;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.verdict = verdict_e'(m_axis_tdata[1:0]);
        got.mask = m_axis_tdata[7:2];
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          if (got.verdict !== want.verdict) begin
            $display("%0t: verdict mismatch: expected %0d, got %0d", $time, want.verdict,
                     got.verdict);
            errors++;
          end
          if (got.mask !== want.mask) begin
            $display("%0t: inside mask mismatch: expected %b, got %b", $time, want.mask,
                     got.mask);
            errors++;
          end
        end
      end
      @(negedge clk_i);
      // one long hold so the pipeline fills and backs up
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        stall_left = 150;
        calm_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 199);
        if (pick < 2) calm_left = $urandom_range(40, 160);
        if (pick < 130) stall_left = 0;
        else if (pick < 180) stall_left = $urandom_range(1, 3);
        else if (pick < 196) stall_left = $urandom_range(4, 10);
        else stall_left = $urandom_range(15, 40);
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // request side: reset, directed table, then random phases
  initial begin : stimulus
    region_req_t rq;
    plane_arr_t  planes;
    logic [15:0] dval;
    int          k, p, i, axis, pick;
    bit          calm_tx;
    calm_tx = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i <= REG_PLANE_FIVE; i++) reg_read_check(i);

    // directed table
    for (k = 0; k < NDir; k++) begin
      case (DirRows[k].act)
        ACT_COUNT: begin
          drain();
          reg_write(REG_PLANE_COUNT, {61'h0, DirRows[k].count});
        end
        ACT_CUBE: begin
          drain();
          load_region(3'd6, CubePlanes);
        end
        ACT_STRAY: begin
          drain();
          reg_write(REG_PLANE_FIVE + 1, {$urandom, $urandom});
        end
        default: ;
      endcase
      send_req(DirRows[k].rq,
               DirRows[k].has_want ? DirRows[k].want : classify(DirRows[k].rq), 1'b0);
    end

    // random phases, each with its own plane set
    for (p = 0; p < NPhase; p++) begin
      drain();
      for (i = 0; i < MaxPlanes; i++) begin
        if (p == 0) begin
          // extreme plane words
          case (i)
            0: planes[i] = 64'h8000_8000_8000_8000;
            1: planes[i] = 64'h7FFF_7FFF_7FFF_7FFF;
            2: planes[i] = 64'h7FFF_8000_7FFF_8000;
            3: planes[i] = 64'h8000_7FFF_8000_7FFF;
            4: planes[i] = 64'h8000_7FFF_7FFF_7FFF;
            default: planes[i] = 64'h7FFF_8000_8000_8000;
          endcase
        end else begin
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            planes[i] = {$urandom, $urandom};
          end else if (pick == 1) begin
            // axis-aligned face at a random offset
            axis = $urandom_range(0, 2);
            dval = 16'($urandom_range(0, 4096));
            planes[i] = {dval, 48'h0};
            planes[i][axis * 16 +: 16] = $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
          end else begin
            planes[i] = {16'($urandom_range(0, 8191) - 4096),
                         16'($urandom_range(0, 1023) - 512),
                         16'($urandom_range(0, 1023) - 512),
                         16'($urandom_range(0, 1023) - 512)};
          end
        end
      end
      load_region((p == NPhase - 1) ? 3'($urandom_range(0, 7)) : PhaseCounts[p], planes);
      if (p == 1) long_hold_due = 1'b1;
      for (k = 0; k < PhaseItems; k++) begin
        if (k % 64 == 0) calm_tx = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 15);
        rq.op = (pick == 0) ? OP_NONE : op_e'(2'((pick - 1) % 3));
        rq.cx = rand_coord();
        rq.cy = rand_coord();
        rq.cz = rand_coord();
        rq.radius = rand_extent();
        rq.hx = rand_extent();
        rq.hy = rand_extent();
        rq.hz = rand_extent();
        send_req(rq, classify(rq), calm_tx);
      end
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
